FILE: design/csi_pkg.sv
`default_nettype none

package csi_pkg;

  localparam int CW   = 32;
  localparam int RADW = CW - 1;
  localparam int DW   = CW + 1;
  localparam int RW   = CW;
  localparam int PRW  = 2 * DW;
  localparam int SW   = PRW;
  localparam int REMW = SW + 1;
  localparam int TF   = 32;
  localparam int TW   = TF + 1;
  localparam int VW   = CW + 2;
  localparam int V2W  = 2 * VW;
  localparam int DSTW = RW;
  localparam int SQW  = 2 * DSTW;
  localparam int NF   = 14;
  localparam int QW   = NF + 2;
  localparam int NW   = 16;

  localparam logic [PRW-1:0] RND_T = PRW'(1) << (TF - 1);

  typedef struct packed {
    logic [2:0][DW-1:0] d;
    logic [2:0][DW-1:0] w;
    logic [RW-1:0]      radi;
  } geom_t;

  typedef struct packed {
    geom_t         g;
    logic [SW-1:0] rem;
    logic [SW-1:0] len2;
    logic          tz;
  } dot_t;

  typedef struct packed {
    geom_t         g;
    logic [TW-1:0] t;
  } tgeom_t;

  typedef struct packed {
    logic [2:0][VW-1:0] v;
    logic [RW-1:0]      radi;
    logic [SQW-1:0]     n;
    logic               hit;
    logic               nv;
  } dist_t;

  typedef struct packed {
    logic [2:0][VW-1:0] v;
    logic [RW-1:0]      radi;
    logic [DSTW-1:0]    dlen;
    logic               hit;
    logic               nv;
  } root_t;

  typedef struct packed {
    logic               hit;
    logic               nv;
    logic [2:0][NW-1:0] n;
    logic [RW-1:0]      pen;
  } result_t;

  function automatic logic [DW-1:0] mag_d(input logic [DW-1:0] x);
    return x[DW-1] ? (~x + DW'(1)) : x;
  endfunction

  function automatic logic [VW-1:0] mag_v(input logic [VW-1:0] x);
    return x[VW-1] ? (~x + VW'(1)) : x;
  endfunction

endpackage

`default_nettype wire

FILE: design/csi_front.sv
`default_nettype none

module csi_front
  import csi_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               ce_i,
  input  logic               valid_i,
  input  logic [2:0][CW-1:0] start_i,
  input  logic [2:0][CW-1:0] stop_i,
  input  logic [2:0][CW-1:0] center_i,
  input  logic [RADW-1:0]    cap_rad_i,
  input  logic [RADW-1:0]    ball_rad_i,
  output logic               valid_o,
  output dot_t               dot_o
);

  logic [3:0]          vld_q;
  geom_t               g1_d, g1_q, g2_q, g3_q;
  logic [2:0][PRW-1:0] pw_d, pw_q, dd_d, dd_q;
  logic [2:0]          ng_d, ng_q;
  logic [SW-1:0]       pos_d, pos_q, neg_d, neg_q, len_d, len_q;
  logic [SW:0]         diff;
  dot_t                dot_d, dot_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      g1_d.d[i] = {stop_i[i][CW-1], stop_i[i]} - {start_i[i][CW-1], start_i[i]};
      g1_d.w[i] = {center_i[i][CW-1], center_i[i]} - {start_i[i][CW-1], start_i[i]};
    end
    g1_d.radi = RW'(cap_rad_i) + RW'(ball_rad_i);
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pw_d[i] = PRW'(mag_d(g1_q.w[i])) * PRW'(mag_d(g1_q.d[i]));
      dd_d[i] = PRW'(mag_d(g1_q.d[i])) * PRW'(mag_d(g1_q.d[i]));
      ng_d[i] = g1_q.w[i][DW-1] ^ g1_q.d[i][DW-1];
    end
  end

  always_comb begin
    pos_d = '0;
    neg_d = '0;
    len_d = '0;
    for (int i = 0; i < 3; i++) begin
      if (ng_q[i]) begin
        neg_d = neg_d + pw_q[i];
      end else begin
        pos_d = pos_d + pw_q[i];
      end
      len_d = len_d + dd_q[i];
    end
  end

  always_comb begin
    diff       = {1'b0, pos_q} - {1'b0, neg_q};
    dot_d.g    = g3_q;
    dot_d.rem  = diff[SW-1:0];
    dot_d.len2 = len_q;
    dot_d.tz   = (len_q == '0) || diff[SW] || (diff[SW-1:0] == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ce_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      g1_q  <= g1_d;
      pw_q  <= pw_d;
      dd_q  <= dd_d;
      ng_q  <= ng_d;
      g2_q  <= g1_q;
      pos_q <= pos_d;
      neg_q <= neg_d;
      len_q <= len_d;
      g3_q  <= g2_q;
      dot_q <= dot_d;
    end
  end

  assign valid_o = vld_q[3];
  assign dot_o   = dot_q;

endmodule

`default_nettype wire

FILE: design/csi_tdiv.sv
`default_nettype none

module csi_tdiv
  import csi_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   ce_i,
  input  logic   valid_i,
  input  dot_t   dot_i,
  output logic   valid_o,
  output tgeom_t tg_o
);

  typedef struct packed {
    geom_t           g;
    logic [REMW-1:0] r;
    logic [SW-1:0]   len2;
    logic [TF-1:0]   q;
    logic            tz;
    logic            tone;
  } div_t;

  logic [TF:0] vld_q;
  div_t        st_d [TF+1];
  div_t        st_q [TF+1];

  for (genvar k = 0; k <= TF; k++) begin : g_stage
    if (k == 0) begin : g_head
      always_comb begin
        st_d[k].g    = dot_i.g;
        st_d[k].r    = {1'b0, dot_i.rem};
        st_d[k].len2 = dot_i.len2;
        st_d[k].q    = '0;
        st_d[k].tz   = dot_i.tz;
        st_d[k].tone = dot_i.rem >= dot_i.len2;
      end
    end else begin : g_step
      logic [REMW-1:0] dbl;
      logic            ge;
      always_comb begin
        dbl       = {st_q[k-1].r[REMW-2:0], 1'b0};
        ge        = dbl >= REMW'(st_q[k-1].len2);
        st_d[k]   = st_q[k-1];
        st_d[k].r = ge ? dbl - REMW'(st_q[k-1].len2) : dbl;
        st_d[k].q = {st_q[k-1].q[TF-2:0], ge};
      end
    end

    always_ff @(posedge clk_i) begin
      if (ce_i) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ce_i) begin
      vld_q <= {vld_q[TF-1:0], valid_i};
    end
  end

  always_comb begin
    tg_o.g = st_q[TF].g;
    if (st_q[TF].tz) begin
      tg_o.t = '0;
    end else if (st_q[TF].tone) begin
      tg_o.t = TW'(1) << TF;
    end else begin
      tg_o.t = {1'b0, st_q[TF].q};
    end
  end

  assign valid_o = vld_q[TF];

endmodule

`default_nettype wire

FILE: design/csi_proj.sv
`default_nettype none

module csi_proj
  import csi_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   ce_i,
  input  logic   valid_i,
  input  tgeom_t tg_i,
  output logic   valid_o,
  output dist_t  dist_o
);

  logic [5:0]          vld_q;
  logic [2:0][PRW-1:0] prod_d, prod_q, rnd;
  geom_t               g1_q, g2_q;
  logic [2:0][VW-1:0]  m_d, m_q, wx, v_d, v3_q, v4_q, v5_q;
  logic [RW-1:0]       rad3_q, rad4_q, rad5_q;
  logic [2:0][V2W-1:0] sq_d, sq_q;
  logic [SQW-1:0]      r2_d, r4_q, r5_q;
  logic [V2W-1:0]      d2_d, d2_q;
  dist_t               dist_d, dist_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod_d[i] = PRW'(mag_d(tg_i.g.d[i])) * PRW'(tg_i.t);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd[i] = prod_q[i] + RND_T;
      m_d[i] = rnd[i][PRW-1:TF];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wx[i]  = {g2_q.w[i][DW-1], g2_q.w[i]};
      v_d[i] = g2_q.d[i][DW-1] ? wx[i] + m_q[i] : wx[i] - m_q[i];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_d[i] = V2W'(mag_v(v3_q[i])) * V2W'(mag_v(v3_q[i]));
    end
    r2_d = SQW'(rad3_q) * SQW'(rad3_q);
  end

  assign d2_d = sq_q[0] + sq_q[1] + sq_q[2];

  always_comb begin
    dist_d.v    = v5_q;
    dist_d.radi = rad5_q;
    dist_d.n    = d2_q[SQW-1:0];
    dist_d.hit  = d2_q < V2W'(r5_q);
    dist_d.nv   = (d2_q < V2W'(r5_q)) && (d2_q > V2W'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ce_i) begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      prod_q <= prod_d;
      g1_q   <= tg_i.g;
      m_q    <= m_d;
      g2_q   <= g1_q;
      v3_q   <= v_d;
      rad3_q <= g2_q.radi;
      sq_q   <= sq_d;
      r4_q   <= r2_d;
      v4_q   <= v3_q;
      rad4_q <= rad3_q;
      d2_q   <= d2_d;
      r5_q   <= r4_q;
      v5_q   <= v4_q;
      rad5_q <= rad4_q;
      dist_q <= dist_d;
    end
  end

  assign valid_o = vld_q[5];
  assign dist_o  = dist_q;

endmodule

`default_nettype wire

FILE: design/csi_sqrt.sv
`default_nettype none

module csi_sqrt
  import csi_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  ce_i,
  input  logic  valid_i,
  input  dist_t dist_i,
  output logic  valid_o,
  output root_t root_o
);

  typedef struct packed {
    logic [SQW-1:0]     op;
    logic [SQW-1:0]     res;
    logic [2:0][VW-1:0] v;
    logic [RW-1:0]      radi;
    logic               hit;
    logic               nv;
  } rt_t;

  logic [DSTW-1:0] vld_q;
  rt_t             st_d [DSTW];
  rt_t             st_q [DSTW];

  for (genvar k = 0; k < DSTW; k++) begin : g_stage
    localparam logic [SQW-1:0] Step = SQW'(1) << (SQW - 2 - 2 * k);
    rt_t            src;
    logic [SQW-1:0] trial;
    logic           ge;

    if (k == 0) begin : g_head
      always_comb begin
        src.op   = dist_i.n;
        src.res  = '0;
        src.v    = dist_i.v;
        src.radi = dist_i.radi;
        src.hit  = dist_i.hit;
        src.nv   = dist_i.nv;
      end
    end else begin : g_tail
      assign src = st_q[k-1];
    end

    always_comb begin
      trial      = src.res + Step;
      ge         = src.op >= trial;
      st_d[k]    = src;
      st_d[k].op = ge ? src.op - trial : src.op;
      st_d[k].res = ge ? (src.res >> 1) + Step : src.res >> 1;
    end

    always_ff @(posedge clk_i) begin
      if (ce_i) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ce_i) begin
      vld_q <= {vld_q[DSTW-2:0], valid_i};
    end
  end

  always_comb begin
    root_o.v    = st_q[DSTW-1].v;
    root_o.radi = st_q[DSTW-1].radi;
    root_o.dlen = st_q[DSTW-1].res[DSTW-1:0];
    root_o.hit  = st_q[DSTW-1].hit;
    root_o.nv   = st_q[DSTW-1].nv;
  end

  assign valid_o = vld_q[DSTW-1];

endmodule

`default_nettype wire

FILE: design/csi_norm.sv
`default_nettype none

module csi_norm
  import csi_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    ce_i,
  input  logic    valid_i,
  input  root_t   root_i,
  output logic    valid_o,
  output result_t res_o
);

  typedef struct packed {
    logic [2:0][VW-1:0] r;
    logic [2:0]         neg;
    logic [2:0][QW-1:0] q;
    logic [DSTW-1:0]    dlen;
    logic [RW-1:0]      pen;
    logic               hit;
    logic               nv;
  } nm_t;

  logic [QW:0]       vld_q;
  nm_t               a_d, a_q;
  nm_t               st_d [QW];
  nm_t               st_q [QW];
  logic [2:0][QW:0]  rnd;
  logic [2:0][QW-1:0] nq;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_d.r[i]   = mag_v(root_i.v[i]);
      a_d.neg[i] = root_i.v[i][VW-1];
    end
    a_d.q    = '0;
    a_d.dlen = root_i.dlen;
    a_d.pen  = root_i.radi - root_i.dlen;
    a_d.hit  = root_i.hit;
    a_d.nv   = root_i.nv;
  end

  for (genvar j = 0; j < QW; j++) begin : g_stage
    nm_t                src;
    logic [2:0][VW-1:0] sh;
    logic [2:0]         ge;

    if (j == 0) begin : g_head
      assign src = a_q;
      assign sh  = a_q.r;
    end else begin : g_tail
      assign src = st_q[j-1];
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          sh[i] = {st_q[j-1].r[i][VW-2:0], 1'b0};
        end
      end
    end

    always_comb begin
      st_d[j] = src;
      for (int i = 0; i < 3; i++) begin
        ge[i]         = sh[i] >= VW'(src.dlen);
        st_d[j].r[i] = ge[i] ? sh[i] - VW'(src.dlen) : sh[i];
        st_d[j].q[i] = {src.q[i][QW-2:0], ge[i]};
      end
    end

    always_ff @(posedge clk_i) begin
      if (ce_i) begin
        st_q[j] <= st_d[j];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ce_i) begin
      vld_q <= {vld_q[QW-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      a_q <= a_d;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd[i] = {1'b0, st_q[QW-1].q[i]} + (QW+1)'(1);
      nq[i]  = rnd[i][QW:1];
      if (!st_q[QW-1].nv) begin
        res_o.n[i] = '0;
      end else if (st_q[QW-1].neg[i]) begin
        res_o.n[i] = NW'(-nq[i]);
      end else begin
        res_o.n[i] = NW'(nq[i]);
      end
    end
    res_o.hit = st_q[QW-1].hit;
    res_o.nv  = st_q[QW-1].nv;
    res_o.pen = st_q[QW-1].hit ? st_q[QW-1].pen : '0;
  end

  assign valid_o = vld_q[QW];

endmodule

`default_nettype wire

FILE: design/capsule_sphere_intersect_top.sv
// Channel  Direction  Handshake                  Word
// in       input      in_valid_i / in_stall_o    segment, capsule radius, sphere
// out      output     out_valid_o / out_stall_i  hit, normal, penetration depth
//
// One word is accepted every cycle while in_stall_o is low; the pipeline holds the 33-step
// projection divider, the 32-step square root and the 16-step normal divider.
// Reset clears only the valid bits of the pipeline, the output and the skid.
// The output register has a skid register behind it; in_stall_o rises when
// the skid holds a word, and the whole pipeline holds until it drains.
`default_nettype none

module capsule_sphere_intersect_top
  import csi_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic signed [CW-1:0] seg_start_x_i,
  input  logic signed [CW-1:0] seg_start_y_i,
  input  logic signed [CW-1:0] seg_start_z_i,
  input  logic signed [CW-1:0] seg_end_x_i,
  input  logic signed [CW-1:0] seg_end_y_i,
  input  logic signed [CW-1:0] seg_end_z_i,
  input  logic [RADW-1:0]      capsule_radius_i,
  input  logic signed [CW-1:0] ball_center_x_i,
  input  logic signed [CW-1:0] ball_center_y_i,
  input  logic signed [CW-1:0] ball_center_z_i,
  input  logic [RADW-1:0]      ball_radius_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 hit_o,
  output logic                 normal_valid_o,
  output logic signed [NW-1:0] normal_x_o,
  output logic signed [NW-1:0] normal_y_o,
  output logic signed [NW-1:0] normal_z_o,
  output logic [RW-1:0]        pen_depth_o
);

  logic               ce, take;
  logic [2:0][CW-1:0] seg_start, seg_stop, center;
  logic               f_vld, t_vld, p_vld, s_vld, pipe_vld;
  dot_t               f_dot;
  tgeom_t             t_geo;
  dist_t              p_dist;
  root_t              s_root;
  result_t            pipe_res, out_q, skid_q;
  logic               out_vld_q, skid_vld_q;

  assign seg_start = {seg_start_z_i, seg_start_y_i, seg_start_x_i};
  assign seg_stop  = {seg_end_z_i, seg_end_y_i, seg_end_x_i};
  assign center    = {ball_center_z_i, ball_center_y_i, ball_center_x_i};

  assign ce   = !skid_vld_q;
  assign take = !out_vld_q || !out_stall_i;

  csi_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ce_i       (ce),
    .valid_i    (in_valid_i),
    .start_i    (seg_start),
    .stop_i     (seg_stop),
    .center_i   (center),
    .cap_rad_i  (capsule_radius_i),
    .ball_rad_i (ball_radius_i),
    .valid_o    (f_vld),
    .dot_o      (f_dot)
  );

  csi_tdiv u_tdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ce_i    (ce),
    .valid_i (f_vld),
    .dot_i   (f_dot),
    .valid_o (t_vld),
    .tg_o    (t_geo)
  );

  csi_proj u_proj (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ce_i    (ce),
    .valid_i (t_vld),
    .tg_i    (t_geo),
    .valid_o (p_vld),
    .dist_o  (p_dist)
  );

  csi_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ce_i    (ce),
    .valid_i (p_vld),
    .dist_i  (p_dist),
    .valid_o (s_vld),
    .root_o  (s_root)
  );

  csi_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ce_i    (ce),
    .valid_i (s_vld),
    .root_i  (s_root),
    .valid_o (pipe_vld),
    .res_o   (pipe_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (take) begin
      out_vld_q  <= skid_vld_q || pipe_vld;
      skid_vld_q <= 1'b0;
    end else if (ce && pipe_vld) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= skid_vld_q ? skid_q : pipe_res;
    end else if (ce) begin
      skid_q <= pipe_res;
    end
  end

  assign in_stall_o     = skid_vld_q;
  assign out_valid_o    = out_vld_q;
  assign hit_o          = out_q.hit;
  assign normal_valid_o = out_q.nv;
  assign normal_x_o     = out_q.n[0];
  assign normal_y_o     = out_q.n[1];
  assign normal_z_o     = out_q.n[2];
  assign pen_depth_o    = out_q.pen;

endmodule

`default_nettype wire

FILE: design/csi_checker.sv
`default_nettype none

module csi_checker
  import csi_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic                 hit_o,
  input logic                 normal_valid_o,
  input logic signed [NW-1:0] normal_x_o,
  input logic signed [NW-1:0] normal_y_o,
  input logic signed [NW-1:0] normal_z_o,
  input logic [RW-1:0]        pen_depth_o
);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i)
    else $error("stalled input word was withdrawn");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(hit_o)
      && $stable(pen_depth_o) && $stable(normal_x_o) && $stable(normal_y_o)
      && $stable(normal_z_o) && $stable(normal_valid_o))
    else $error("stalled output word changed");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> !normal_valid_o && pen_depth_o == '0
      && normal_x_o == '0 && normal_y_o == '0 && normal_z_o == '0)
    else $error("miss word carries nonzero fields");

  a_nv_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && normal_valid_o |-> hit_o)
    else $error("normal flagged valid without a hit");

  a_hit_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> pen_depth_o != '0)
    else $error("hit with zero penetration depth");

endmodule

bind capsule_sphere_intersect_top csi_checker u_csi_checker (.*);

`default_nettype wire

FILE: tb/sv/capsule_sphere_intersect_top_tb.sv
`default_nettype none

module capsule_sphere_intersect_top_tb;
  import csi_pkg::*;

  typedef struct {
    logic signed [CW-1:0] s [3];
    logic signed [CW-1:0] e [3];
    logic [RADW-1:0]      rc;
    logic signed [CW-1:0] c [3];
    logic [RADW-1:0]      rs;
  } query_t;

  typedef struct {
    logic               hit;
    logic               nv;
    logic signed [15:0] n [3];
    logic [31:0]        pen;
  } contact_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [CW-1:0] seg_start_x_i = '0, seg_start_y_i = '0, seg_start_z_i = '0;
  logic signed [CW-1:0] seg_end_x_i = '0, seg_end_y_i = '0, seg_end_z_i = '0;
  logic [RADW-1:0] capsule_radius_i = '0, ball_radius_i = '0;
  logic signed [CW-1:0] ball_center_x_i = '0, ball_center_y_i = '0, ball_center_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic hit_o, normal_valid_o;
  logic signed [NW-1:0] normal_x_o, normal_y_o, normal_z_o;
  logic [RW-1:0] pen_depth_o;

  capsule_sphere_intersect_top dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  query_t   pending_queries [$];
  contact_t expected_contacts [$];
  int       errors = 0;
  int       cycles = 0;
  bit       hold_off = 1'b0;
  bit       feeding_done = 1'b0;

  function automatic logic [127:0] isqrt128(input logic [127:0] n);
    logic [127:0] r;
    logic [127:0] cand;
    r = '0;
    for (int b = 36; b >= 0; b--) begin
      cand = r | (128'd1 << b);
      if (cand * cand <= n) r = cand;
    end
    return r;
  endfunction

  function automatic contact_t predict_contact(input query_t q);
    contact_t o;
    logic signed [127:0] d [3], w [3], v [3];
    logic signed [127:0] dot, len2, dist2, qq;
    logic [127:0] t, m, radi, dlen, r, nq;
    o.hit = 0; o.nv = 0; o.pen = 0;
    for (int i = 0; i < 3; i++) o.n[i] = 0;
    dot = 0; len2 = 0; dist2 = 0;
    for (int i = 0; i < 3; i++) begin
      d[i] = 128'(q.e[i]) - 128'(q.s[i]);
      w[i] = 128'(q.c[i]) - 128'(q.s[i]);
      dot += d[i] * w[i];
      len2 += d[i] * d[i];
    end
    if (len2 == 0 || dot <= 0) t = 0;
    else if (dot >= len2) t = 128'd1 << 32;
    else t = (128'(dot) << 32) / 128'(len2);
    for (int i = 0; i < 3; i++) begin
      m = ((d[i] < 0 ? -d[i] : d[i]) * t + (128'd1 << 31)) >> 32;
      qq = d[i] < 0 ? -$signed(m) : $signed(m);
      v[i] = w[i] - qq;
      dist2 += v[i] * v[i];
    end
    radi = 128'(q.rc) + 128'(q.rs);
    if (dist2 >= $signed(radi * radi)) return o;
    dlen = isqrt128(dist2);
    o.hit = 1;
    o.pen = 32'(radi - dlen);
    if (dist2 > 1) begin
      o.nv = 1;
      for (int i = 0; i < 3; i++) begin
        r = v[i] < 0 ? -v[i] : v[i];
        nq = (((r << 15) / dlen) + 1) >> 1;
        o.n[i] = v[i] < 0 ? -16'(nq) : 16'(nq);
      end
    end
    return o;
  endfunction

  function automatic logic signed [CW-1:0] rand_coord(input int scale);
    case (scale)
      0: return $signed($urandom);
      1: return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
      default: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
    endcase
  endfunction

  task automatic add_query(input query_t q);
    pending_queries.push_back(q);
  endtask

  initial begin
    query_t q;
    logic signed [CW-1:0] ext [4];
    int sc;
    ext = '{32'sh8000_0000, 32'sh7FFF_FFFF, 0, -1};
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 3; i++) begin
        q.s[i] = ext[k]; q.e[i] = ext[3 - k]; q.c[i] = ext[(k + i) % 4];
      end
      q.rc = k[0] ? '1 : '0; q.rs = k[1] ? '1 : '0;
      add_query(q);
    end
    for (int k = 0; k < 6; k++) begin
      for (int i = 0; i < 3; i++) begin
        q.s[i] = 32'sh0001_0000 * i; q.e[i] = q.s[i];
        q.c[i] = q.s[i] + (k < 2 ? k : (k - 1) * 32'sh0000_4000 * (i + 1));
      end
      q.c[0] = q.c[0] - k;
      q.rc = 31'h0001_0000; q.rs = k == 5 ? '1 : 31'h0000_8000;
      add_query(q);
    end
    for (int k = 0; k < 6; k++) begin
      q.s = '{0, 0, 0};
      q.e = '{32'sh0004_0000, 0, 0};
      q.c = '{(k - 1) * 32'sh0001_0000, 32'sh0000_8000 * (k % 3), -(k % 2)};
      q.rc = 31'h0000_8000; q.rs = 31'h0000_4000 * k;
      add_query(q);
    end
    for (int n = 0; n < 1250; n++) begin
      sc = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 2);
      for (int i = 0; i < 3; i++) begin
        q.s[i] = rand_coord(sc);
        q.e[i] = $urandom_range(0, 9) == 0 ? q.s[i] : rand_coord(sc);
        q.c[i] = rand_coord(sc);
      end
      if (sc == 0) begin
        q.rc = $urandom; q.rs = $urandom;
      end else begin
        q.rc = $urandom_range(0, 32'h0080_0000);
        q.rs = $urandom_range(0, 32'h0080_0000);
      end
      add_query(q);
    end
    feeding_done = 1'b1;
  end

  int send_gap = 0;
  always @(posedge clk_i) begin
    query_t q;
    if (rst_ni && !(in_valid_i && in_stall_o)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (pending_queries.size() > 0) begin
        q = pending_queries.pop_front();
        expected_contacts.push_back(predict_contact(q));
        in_valid_i <= 1'b1;
        {seg_start_x_i, seg_start_y_i, seg_start_z_i} <= {q.s[0], q.s[1], q.s[2]};
        {seg_end_x_i, seg_end_y_i, seg_end_z_i} <= {q.e[0], q.e[1], q.e[2]};
        {ball_center_x_i, ball_center_y_i, ball_center_z_i} <= {q.c[0], q.c[1], q.c[2]};
        capsule_radius_i <= q.rc;
        ball_radius_i <= q.rs;
        if ($urandom_range(0, 3) == 0)
          send_gap <= $urandom_range(0, 19) == 0 ? $urandom_range(10, 60) : $urandom_range(1, 3);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  int recv_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_off) out_stall_i <= 1'b1;
      else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_stall_i <= 1'b1;
      end else if ($urandom_range(0, 4) == 0) begin
        recv_gap <= $urandom_range(0, 19) == 0 ? $urandom_range(10, 80) : $urandom_range(0, 3);
        out_stall_i <= 1'b1;
      end else out_stall_i <= 1'b0;
    end
  end

  initial begin
    repeat (400) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (300) @(posedge clk_i);
    hold_off = 1'b0;
  end

  always @(posedge clk_i) begin
    contact_t x;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_contacts.size() == 0) begin
        $display("%0t: unexpected word hit=%0b", $time, hit_o);
        errors++;
      end else begin
        x = expected_contacts.pop_front();
        if (hit_o !== x.hit || normal_valid_o !== x.nv || normal_x_o !== x.n[0] ||
            normal_y_o !== x.n[1] || normal_z_o !== x.n[2] || pen_depth_o !== x.pen) begin
          $display("%0t: expected hit=%0b nv=%0b n=%0d,%0d,%0d pen=%h", $time,
                   x.hit, x.nv, x.n[0], x.n[1], x.n[2], x.pen);
          $display("%0t: actual   hit=%0b nv=%0b n=%0d,%0d,%0d pen=%h", $time,
                   hit_o, normal_valid_o, normal_x_o, normal_y_o, normal_z_o, pen_depth_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (feeding_done && pending_queries.size() == 0);
    @(posedge clk_i);
    while (in_valid_i || expected_contacts.size() > 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire
